// File: hw/rtl/bgs_pkg.sv
`timescale 1ns / 1ps
// bgs_pkg: shared constants, codes and types for the brightness-to-glyph block
// no dependencies

package bgs_pkg;

  // table geometry
  localparam int unsigned TABLE_DEPTH_DEF = 256;

  // field widths fixed by the interface
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned SLOT_W      = 8;
  localparam int unsigned TEX_W       = 16;
  localparam int unsigned SIZE_W      = 9;
  localparam int unsigned CELL_W      = 8;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 9;

  // register reset values
  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 9'd2;
  localparam logic [CELL_W-1:0] CELL_WIDTH_RST = 8'd8;
  localparam logic [SIZE_W-1:0] TABLE_SIZE_MIN = 9'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH = 1'b1;

  // transaction kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // search sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // finished result from the search unit
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } res_t;

endpackage

// File: hw/rtl/brightness_to_glyph_select.sv
`timescale 1ns / 1ps
// brightness_to_glyph_select: top level, config registers, table, search, output stage
// depends on bgs_pkg, bgs_table, bgs_search

// Maps an RGB pixel to a glyph slot of a text-art font texture. Load transactions
// (kind 0) write one entry of the level/slot table and finish in the cycle they
// are taken; an index at or beyond the table depth is dropped. Pixel transactions
// (kind 1) take brightness as max(red, green, blue), scan the table from entry 0
// for the first level at or above it (clamped to the last entry and to entry 1),
// then return the nearer of that entry and the one below, ties going low, with
// its texture span slot*cell_width and (slot+1)*cell_width. The table is read
// through a single port, one entry a cycle, and one comparator checks each entry;
// a pixel holds off the input until its result leaves the search unit, and the
// scan stops at an index from 1 to the last entry, so dark pixels finish soonest.
// The result sits in an output register, so the next transaction is taken while
// a result waits. Table entries are undefined until loaded and need no clearing
// after reset. Write the config registers only while the block is idle.

module brightness_to_glyph_select
  import bgs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input transactions
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [7:0]            in_entry_index,
  input  logic [CHAN_W-1:0]     in_entry_level,
  input  logic [SLOT_W-1:0]     in_entry_slot,
  input  logic [CHAN_W-1:0]     in_red,
  input  logic [CHAN_W-1:0]     in_green,
  input  logic [CHAN_W-1:0]     in_blue,
  // result transactions
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SLOT_W-1:0]     out_glyph_slot,
  output logic [TEX_W-1:0]      out_tex_left,
  output logic [TEX_W-1:0]      out_tex_right,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  // config registers
  logic [SIZE_W-1:0] table_size_r;
  logic [CELL_W-1:0] cell_width_r;

  // handshake
  logic in_accept;
  logic busy;
  logic take;
  logic out_valid_r;

  // table port
  logic              wr_en;
  logic [AW-1:0]     rd_addr;
  logic [CHAN_W-1:0] rd_level;
  logic [SLOT_W-1:0] rd_slot;

  // pixel setup
  logic [CHAN_W-1:0] max_rg;
  logic [CHAN_W-1:0] bright;
  logic [SIZE_W-1:0] eff_size;
  logic [AW-1:0]     last_idx;
  logic              start;

  res_t res;

  // output stage registers
  logic [SLOT_W-1:0] glyph_slot_r;
  logic [TEX_W-1:0]  tex_left_r;
  logic [TEX_W-1:0]  tex_right_r;

  // config writes, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= TABLE_SIZE_RST;
      cell_width_r <= CELL_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TABLE_SIZE: table_size_r <= cfg_wdata[SIZE_W-1:0];
        CFG_CELL_WIDTH: cell_width_r <= cfg_wdata[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  // input is held off only while a pixel search is in flight
  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;

  // loads go straight into the table; out-of-range indexes are dropped
  assign wr_en = in_accept && (in_kind == KIND_LOAD)
                 && ({1'b0, in_entry_index} < SIZE_W'(TABLE_DEPTH));

  // brightness is the largest color component
  assign max_rg = (in_green > in_red) ? in_green : in_red;
  assign bright = (in_blue > max_rg) ? in_blue : max_rg;

  // usable table size clamped to [2, depth]
  always_comb begin
    if (table_size_r < TABLE_SIZE_MIN) begin
      eff_size = TABLE_SIZE_MIN;
    end else if (table_size_r > SIZE_W'(TABLE_DEPTH)) begin
      eff_size = SIZE_W'(TABLE_DEPTH);
    end else begin
      eff_size = table_size_r;
    end
  end
  assign last_idx = AW'(eff_size - SIZE_W'(1));

  assign start = in_accept && (in_kind == KIND_PIXEL);

  bgs_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (in_entry_index[AW-1:0]),
    .wr_level (in_entry_level),
    .wr_slot  (in_entry_slot),
    .rd_addr  (rd_addr),
    .rd_level (rd_level),
    .rd_slot  (rd_slot)
  );

  bgs_search #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_search (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .bright   (bright),
    .last_idx (last_idx),
    .rd_level (rd_level),
    .rd_slot  (rd_slot),
    .take     (take),
    .rd_addr  (rd_addr),
    .busy     (busy),
    .res      (res)
  );

  // result moves into the output register once it is empty or draining
  assign take = res.valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // texture span: two small multiplies into the output register
  always_ff @(posedge clk) begin
    if (take) begin
      glyph_slot_r <= res.slot;
      tex_left_r   <= TEX_W'({8'd0, res.slot} * {8'd0, cell_width_r});
      tex_right_r  <= TEX_W'(({8'd0, res.slot} + 16'd1) * {8'd0, cell_width_r});
    end
  end

  assign out_valid      = out_valid_r;
  assign out_glyph_slot = glyph_slot_r;
  assign out_tex_left   = tex_left_r;
  assign out_tex_right  = tex_right_r;

endmodule

// File: hw/rtl/bgs_table.sv
`timescale 1ns / 1ps
// bgs_table: level/slot table memory, one write port, one registered read port
// depends on bgs_pkg

module bgs_table
  import bgs_pkg::*;
#(
  parameter int unsigned DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [CHAN_W-1:0] wr_level,
  input  logic [SLOT_W-1:0] wr_slot,
  input  logic [AW-1:0]     rd_addr,
  output logic [CHAN_W-1:0] rd_level,
  output logic [SLOT_W-1:0] rd_slot
);

  logic [CHAN_W-1:0] level_mem [DEPTH];
  logic [SLOT_W-1:0] slot_mem  [DEPTH];
  logic [CHAN_W-1:0] rd_level_r;
  logic [SLOT_W-1:0] rd_slot_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      level_mem[wr_addr] <= wr_level;
      slot_mem[wr_addr]  <= wr_slot;
    end
  end

  always_ff @(posedge clk) begin
    rd_level_r <= level_mem[rd_addr];
    rd_slot_r  <= slot_mem[rd_addr];
  end

  assign rd_level = rd_level_r;
  assign rd_slot  = rd_slot_r;

endmodule

// File: hw/rtl/bgs_search.sv
`timescale 1ns / 1ps
// bgs_search: sequencer that scans the table one entry a cycle with a single
// comparator and picks the nearer of the two neighbor entries; uses bgs_pkg

module bgs_search
  import bgs_pkg::*;
#(
  parameter int unsigned DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CHAN_W-1:0] bright,
  input  logic [AW-1:0]     last_idx,
  input  logic [CHAN_W-1:0] rd_level,
  input  logic [SLOT_W-1:0] rd_slot,
  input  logic              take,
  output logic [AW-1:0]     rd_addr,
  output logic              busy,
  output res_t              res
);

  state_t            state_r, state_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     last_r, last_nxt;
  logic [CHAN_W-1:0] bright_r, bright_nxt;
  logic              hit0_r, hit0_nxt;
  logic [CHAN_W-1:0] prev_level_r, prev_level_nxt;
  logic [SLOT_W-1:0] prev_slot_r, prev_slot_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;

  logic              ge;
  logic              stop;
  logic              nearer_upper;
  logic [CHAN_W:0]   pair_sum;
  logic [CHAN_W:0]   bright_x2;

  // shared compare unit: level against brightness
  assign ge = (rd_level >= bright_r);
  // upper entry wins when level + prev < 2 * bright (tie goes low)
  assign pair_sum     = {1'b0, rd_level} + {1'b0, prev_level_r};
  assign bright_x2    = {bright_r, 1'b0};
  assign nearer_upper = (pair_sum < bright_x2);
  assign stop         = hit0_r || ge || (idx_r == last_r);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    last_nxt       = last_r;
    bright_nxt     = bright_r;
    hit0_nxt       = hit0_r;
    prev_level_nxt = prev_level_r;
    prev_slot_nxt  = prev_slot_r;
    res_slot_nxt   = res_slot_r;
    rd_addr        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          idx_nxt    = '0;
          last_nxt   = last_idx;
          bright_nxt = bright;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_addr = idx_r + AW'(1);
        if (idx_r == '0) begin
          // entry 0 is never the answer on its own, step to entry 1
          hit0_nxt       = ge;
          prev_level_nxt = rd_level;
          prev_slot_nxt  = rd_slot;
          idx_nxt        = idx_r + AW'(1);
        end else if (stop) begin
          res_slot_nxt = nearer_upper ? rd_slot : prev_slot_r;
          state_nxt    = S_DONE;
        end else begin
          prev_level_nxt = rd_level;
          prev_slot_nxt  = rd_slot;
          idx_nxt        = idx_r + AW'(1);
        end
      end
      S_DONE: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    last_r       <= last_nxt;
    bright_r     <= bright_nxt;
    hit0_r       <= hit0_nxt;
    prev_level_r <= prev_level_nxt;
    prev_slot_r  <= prev_slot_nxt;
    res_slot_r   <= res_slot_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign res.valid = (state_r == S_DONE);
  assign res.slot  = res_slot_r;

endmodule

// File: hw/rtl/bgs_checker.sv
`timescale 1ns / 1ps
// bgs_checker: port-level assertions for brightness_to_glyph_select, with bind
// depends on bgs_pkg

module bgs_checker
  import bgs_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  in_kind,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [SLOT_W-1:0]     out_glyph_slot,
  input logic [TEX_W-1:0]      out_tex_left,
  input logic [TEX_W-1:0]      out_tex_right
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_glyph_slot)
      && $stable(out_tex_left) && $stable(out_tex_right))
    else $error("stalled result changed");

  // a pixel transaction always starts a search that holds off the input
  a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind == KIND_PIXEL) |=> in_stall)
    else $error("input not held off after pixel transaction");

  // span is ordered, slot zero starts at texel zero
  a_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tex_right >= out_tex_left)
      && ((out_glyph_slot != '0) || (out_tex_left == '0)))
    else $error("texture span inconsistent with slot");

  // reset empties the output register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind brightness_to_glyph_select bgs_checker u_bgs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_kind        (in_kind),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_glyph_slot (out_glyph_slot),
  .out_tex_left   (out_tex_left),
  .out_tex_right  (out_tex_right)
);
